// ----- rtl/core/owda_pkg.sv -----
// ----------------------------------------------------------------------------
// owda_pkg
// Shared types and codes for the one-way elevator disk arbiter.
// ----------------------------------------------------------------------------
package owda_pkg;

  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_SHIFT,
    S_SHIFT_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_scan;
    logic scan_step;
    logic flip;
    logic start_shift;
    logic shift_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic long_op;
    logic out_pending;
    logic scan_last;
    logic best_found;
    logic best_last;
    logic shift_last;
  } sts_t;

endpackage

// ----- rtl/core/owda_dp.sv -----
// ----------------------------------------------------------------------------
// owda_dp
// Datapath: waiting store, sweep scan, store compaction and result register.
// ----------------------------------------------------------------------------
module owda_dp #(
  parameter int QD = 16,
  parameter int TB = 16,
  parameter int CB = 4,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_op,
  input  logic [CB-1:0]      in_requester_id,
  input  logic [TB-1:0]      in_track,
  input  owda_pkg::cmd_t     cmd,
  output owda_pkg::sts_t     sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [CB-1:0]      out_grant_id,
  output logic [TB-1:0]      out_grant_track,
  output logic               out_disk_busy,
  output logic [CW-1:0]      out_waiting_count
);
  import owda_pkg::*;

  localparam int EW = TB + CB + 1;

  logic [EW-1:0] mem [QD];
  logic [EW-1:0] rd_q_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic          held_r, cur_r, out_valid_r, pend_r, shift_mode_r, best_found_r;
  logic [TB-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] ptr_r, rd_idx_d_r, best_idx_r;
  logic [TB-1:0] best_trk_r;
  logic [CB-1:0] best_cli_r;

  logic [1:0]    o_status_r;
  logic [CB-1:0] o_id_r;
  logic [TB-1:0] o_trk_r;
  logic          o_busy_r;
  logic [CW-1:0] o_cnt_r;

  logic          full, enqueue, eval_hit, e_sw;
  logic [TB-1:0] e_trk;
  logic [CB-1:0] e_cli;
  logic [CW-1:0] cnt_m1;

  assign full    = (count_r == CW'(QD));
  assign enqueue = cmd.accept && !sts.long_op && (in_op == OP_REQUEST) && held_r && !full;
  assign cnt_m1  = count_r - CW'(1);

  assign e_trk = rd_q_r[TB-1:0];
  assign e_cli = rd_q_r[TB+CB-1:TB];
  assign e_sw  = rd_q_r[EW-1];
  // Strict compare while walking upwards keeps the oldest of equal tracks.
  assign eval_hit = pend_r && !shift_mode_r && (e_sw == cur_r) &&
                    (!best_found_r || (e_trk < best_trk_r));

  assign rd_addr = cmd.shift_step ? ptr_r + AW'(1) : ptr_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = {((in_track < head_r) ? ~cur_r : cur_r), in_requester_id, in_track};
    if (enqueue) begin
      wr_en = 1'b1;
    end else if (pend_r && shift_mode_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_d_r - AW'(1);
      wr_data = rd_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    sts.long_op     = (in_op == OP_RELEASE) && (count_r != '0);
    sts.out_pending = out_valid_r;
    sts.scan_last   = (CW'(ptr_r) == cnt_m1);
    sts.best_found  = best_found_r;
    sts.best_last   = (CW'(best_idx_r) == cnt_m1);
    sts.shift_last  = (CW'(ptr_r) + CW'(1) == cnt_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 1'b0;
      cur_r        <= 1'b0;
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      shift_mode_r <= 1'b0;
      best_found_r <= 1'b0;
      ptr_r        <= '0;
    end else begin
      pend_r <= cmd.scan_step || cmd.shift_step;
      if (cmd.scan_step || cmd.shift_step) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (eval_hit) begin
        best_found_r <= 1'b1;
      end
      if (cmd.start_scan) begin
        ptr_r        <= '0;
        best_found_r <= 1'b0;
        shift_mode_r <= 1'b0;
      end
      if (cmd.flip) begin
        cur_r <= ~cur_r;
      end
      if (cmd.start_shift) begin
        ptr_r        <= best_idx_r;
        shift_mode_r <= 1'b1;
        head_r       <= best_trk_r;
      end
      if (cmd.finish) begin
        count_r <= cnt_m1;
        held_r  <= 1'b1;
      end
      if (cmd.accept && !sts.long_op) begin
        if (in_op == OP_REQUEST) begin
          if (!held_r) begin
            held_r <= 1'b1;
            head_r <= in_track;
          end else if (!full) begin
            count_r <= count_r + CW'(1);
          end
        end else begin
          held_r <= 1'b0;
        end
      end
      if (cmd.finish || (cmd.accept && !sts.long_op)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step || cmd.shift_step) begin
      rd_idx_d_r <= rd_addr;
    end
    if (eval_hit) begin
      best_idx_r <= rd_idx_d_r;
      best_trk_r <= e_trk;
      best_cli_r <= e_cli;
    end
    if (cmd.finish) begin
      o_status_r <= ST_GRANTED;
      o_id_r     <= best_cli_r;
      o_trk_r    <= best_trk_r;
      o_busy_r   <= 1'b1;
      o_cnt_r    <= cnt_m1;
    end else if (cmd.accept && !sts.long_op) begin
      o_id_r  <= '0;
      o_trk_r <= '0;
      o_cnt_r <= count_r;
      if (in_op == OP_REQUEST) begin
        o_busy_r <= 1'b1;
        if (!held_r) begin
          o_status_r <= ST_GRANTED;
          o_id_r     <= in_requester_id;
          o_trk_r    <= in_track;
        end else if (full) begin
          o_status_r <= ST_FULL;
        end else begin
          o_status_r <= ST_QUEUED;
          o_cnt_r    <= count_r + CW'(1);
        end
      end else begin
        o_status_r <= ST_IDLE;
        o_busy_r   <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_grant_id      = o_id_r;
  assign out_grant_track   = o_trk_r;
  assign out_disk_busy     = o_busy_r;
  assign out_waiting_count = o_cnt_r;

endmodule

// ----- rtl/core/owda_ctrl.sv -----
// ----------------------------------------------------------------------------
// owda_ctrl
// Controller: sequences the sweep scan and store compaction of a release.
// ----------------------------------------------------------------------------
module owda_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  owda_pkg::sts_t sts,
  output owda_pkg::cmd_t cmd
);
  import owda_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !sts.out_pending || out_ready;
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (sts.long_op) begin
            cmd.start_scan = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.best_found) begin
          cmd.start_shift = 1'b1;
          state_nxt       = sts.best_last ? S_FINISH : S_SHIFT;
        end else begin
          // Nothing left in this sweep, so the next sweep becomes current.
          cmd.flip       = 1'b1;
          cmd.start_scan = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_last) begin
          state_nxt = S_SHIFT_DRAIN;
        end
      end
      S_SHIFT_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/one_way_elevator_disk_arbiter_unit.sv -----
// ----------------------------------------------------------------------------
// one_way_elevator_disk_arbiter_unit
// C-LOOK disk access arbiter with a packed store of waiting requests.
// ----------------------------------------------------------------------------
// A request, and a release with nothing waiting, is handled at acceptance and
// its result appears in the output register the cycle after acceptance. A
// release with N requests waiting walks the store in a memory with one read
// and one write port, one entry per cycle: a pass over the current sweep, a
// second pass when the current sweep is empty, and then the granted entry is
// removed by copying the later entries down one per cycle, with no copying
// when it is the last entry. A new item is taken only once the previous one
// has finished.
module one_way_elevator_disk_arbiter_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TRACK_BITS  = 16,
  parameter int CLIENT_BITS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [CLIENT_BITS-1:0]             in_requester_id,
  input  logic [TRACK_BITS-1:0]              in_track,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [CLIENT_BITS-1:0]             out_grant_id,
  output logic [TRACK_BITS-1:0]              out_grant_track,
  output logic                               out_disk_busy,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_waiting_count
);
  import owda_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t cmd;
  sts_t sts;

  owda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  owda_dp #(
    .QD (QUEUE_DEPTH),
    .TB (TRACK_BITS),
    .CB (CLIENT_BITS),
    .AW (AW),
    .CW (CW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_requester_id   (in_requester_id),
    .in_track          (in_track),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_grant_id      (out_grant_id),
    .out_grant_track   (out_grant_track),
    .out_disk_busy     (out_disk_busy),
    .out_waiting_count (out_waiting_count)
  );

endmodule
